// ===== rtl/dose_rate_alarm_monitor_defines.svh =====
// Assertion macros for the dose rate alarm monitor checkers.
`ifndef DOSE_RATE_ALARM_MONITOR_DEFINES_SVH
`define DOSE_RATE_ALARM_MONITOR_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define DRM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// cons must hold on the clock edge after ante
`define DRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/drm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package drm_pkg;

    localparam logic [3:0]  ALARM_CONFIRM    = 4'd2;
    localparam logic [3:0]  PREALARM_CONFIRM = 4'd2;
    localparam logic [3:0]  RUN_MAX          = 4'd15;
    localparam logic [9:0]  QUIET_MAX        = 10'd1023;
    localparam logic [9:0]  QUIET_LOW        = 10'd60;
    localparam logic [9:0]  QUIET_ANY        = 10'd600;
    localparam logic [31:0] LIMIT_LOW        = 32'd51_200_000;
    localparam logic [31:0] LIMIT_HIGH       = 32'd2_560_000_000;
    localparam logic [47:0] DOSE_LIMIT       = 48'd9_216_000_000_000;

    localparam int FLAG_ALARM    = 0;
    localparam int FLAG_PREALARM = 1;
    localparam int FLAG_OVER     = 2;
    localparam int FLAG_NOSIG    = 3;

    typedef enum logic {
        REG_ALARM_LEVEL    = 1'b0,
        REG_PREALARM_LEVEL = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [3:0]  alarm_run;
        logic [3:0]  prealarm_run;
        logic [9:0]  quiet_ticks;
        logic [47:0] dose_accum;
        logic [3:0]  flag_bits;
    } t_state;

    typedef struct packed {
        logic [31:0] rate_out;
        logic        rate_alarm;
        logic        rate_prealarm;
        logic        over_range;
        logic        no_signal;
        logic        flags_changed;
        logic [47:0] dose_total;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/drm_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

module drm_eval import drm_pkg::*; (
    input  wire logic [32:0] i_rate_in,
    input  wire logic        i_no_counts,
    input  wire logic        i_high_range,
    input  wire logic [31:0] i_alarm_level,
    input  wire logic [31:0] i_prealarm_level,
    input  wire t_state      i_state,
    output t_state           o_state,
    output t_result          o_result
);

    logic [31:0] rate;
    logic [31:0] limit;
    logic [31:0] rate_sub;
    logic        alarm_hit;
    logic        pre_hit;
    logic        alarm;
    logic        pre;
    logic        over;
    logic        nosig;
    logic [3:0]  flags;
    logic [48:0] sum;

    always_comb begin
        rate = i_rate_in[32] ? 32'd0 : i_rate_in[31:0];

        if (!i_no_counts) begin
            o_state.quiet_ticks = '0;
        end else if (i_state.quiet_ticks == QUIET_MAX) begin
            o_state.quiet_ticks = i_state.quiet_ticks;
        end else begin
            o_state.quiet_ticks = i_state.quiet_ticks + 10'd1;
        end

        alarm_hit = (rate >= i_alarm_level) && (i_alarm_level != 32'd0);
        if (!alarm_hit) begin
            o_state.alarm_run = '0;
        end else if (i_state.alarm_run == RUN_MAX) begin
            o_state.alarm_run = i_state.alarm_run;
        end else begin
            o_state.alarm_run = i_state.alarm_run + 4'd1;
        end
        alarm = alarm_hit && ((o_state.alarm_run >= ALARM_CONFIRM)
                              || i_state.flag_bits[FLAG_ALARM]);

        pre_hit = (rate >= i_prealarm_level) && (rate < i_alarm_level);
        if (!pre_hit) begin
            o_state.prealarm_run = '0;
        end else if (i_state.prealarm_run == RUN_MAX) begin
            o_state.prealarm_run = i_state.prealarm_run;
        end else begin
            o_state.prealarm_run = i_state.prealarm_run + 4'd1;
        end
        pre = pre_hit && ((o_state.prealarm_run >= PREALARM_CONFIRM)
                          || i_state.flag_bits[FLAG_PREALARM]);

        limit    = i_high_range ? LIMIT_HIGH : LIMIT_LOW;
        over     = (i_state.dose_accum >= DOSE_LIMIT) || (rate >= limit);
        rate_sub = over ? limit : rate;

        nosig = ((o_state.quiet_ticks > QUIET_LOW) && !i_high_range)
                || (o_state.quiet_ticks > QUIET_ANY);

        flags                   = '0;
        flags[FLAG_ALARM]       = alarm;
        flags[FLAG_PREALARM]    = pre;
        flags[FLAG_OVER]        = over;
        flags[FLAG_NOSIG]       = nosig;
        o_state.flag_bits       = flags;

        sum = {1'b0, i_state.dose_accum} + {17'd0, rate_sub};
        o_state.dose_accum = sum[48] ? {48{1'b1}} : sum[47:0];

        o_result.rate_out      = rate_sub;
        o_result.rate_alarm    = alarm;
        o_result.rate_prealarm = pre;
        o_result.over_range    = over;
        o_result.no_signal     = nosig;
        o_result.flags_changed = flags != i_state.flag_bits;
        o_result.dose_total    = o_state.dose_accum;
    end

endmodule

`default_nettype wire

// ===== rtl/dose_rate_alarm_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted word passes from the input register to the result register.
// Throughput: one word per cycle; the input register, state update and result
// register form a single pass, so only output stall slows the block.
// Reset (synchronous, active low) clears valids, all tick state and both
// threshold registers.

module dose_rate_alarm_monitor import drm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [32:0] i_rate_in,
    input  wire logic        i_no_counts,
    input  wire logic        i_high_range,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_rate_out,
    output logic             o_rate_alarm,
    output logic             o_rate_prealarm,
    output logic             o_over_range,
    output logic             o_no_signal,
    output logic             o_flags_changed,
    output logic [47:0]      o_dose_total,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        r_in_vld;
    logic [32:0] r_rate_in;
    logic        r_no_counts;
    logic        r_high_range;
    logic        r_out_vld;
    t_result     r_res;
    t_state      r_state;
    t_state      n_state;
    t_result     n_res;
    logic [31:0] r_alarm_level;
    logic [31:0] r_prealarm_level;
    logic        advance;
    logic        cfg_wr;
    t_reg_idx    reg_idx;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    drm_eval u_eval (
        .i_rate_in        (r_rate_in),
        .i_no_counts      (r_no_counts),
        .i_high_range     (r_high_range),
        .i_alarm_level    (r_alarm_level),
        .i_prealarm_level (r_prealarm_level),
        .i_state          (r_state),
        .o_state          (n_state),
        .o_result         (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_rate_in    <= i_rate_in;
            r_no_counts  <= i_no_counts;
            r_high_range <= i_high_range;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_level    <= '0;
            r_prealarm_level <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ALARM_LEVEL:    r_alarm_level    <= pwdata;
                REG_PREALARM_LEVEL: r_prealarm_level <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ALARM_LEVEL:    prdata = r_alarm_level;
            REG_PREALARM_LEVEL: prdata = r_prealarm_level;
            default:            prdata = '0;
        endcase
    end

    assign o_out_valid     = r_out_vld;
    assign o_rate_out      = r_res.rate_out;
    assign o_rate_alarm    = r_res.rate_alarm;
    assign o_rate_prealarm = r_res.rate_prealarm;
    assign o_over_range    = r_res.over_range;
    assign o_no_signal     = r_res.no_signal;
    assign o_flags_changed = r_res.flags_changed;
    assign o_dose_total    = r_res.dose_total;

endmodule

`default_nettype wire

// ===== rtl/drm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "dose_rate_alarm_monitor_defines.svh"

module drm_checker import drm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] o_rate_out,
    input  wire logic        o_rate_alarm,
    input  wire logic        o_rate_prealarm,
    input  wire logic        o_over_range,
    input  wire logic [47:0] o_dose_total
);

    `DRM_ASSERT_ALWAYS(a_alarm_excl, !(o_out_valid && o_rate_alarm && o_rate_prealarm), "alarm and prealarm both set")
    `DRM_ASSERT_ALWAYS(a_rate_cap, !o_out_valid || (o_rate_out <= LIMIT_HIGH), "rate above high range limit")
    `DRM_ASSERT_ALWAYS(a_over_limit, !(o_out_valid && o_over_range) || (o_rate_out == LIMIT_LOW) || (o_rate_out == LIMIT_HIGH), "over range rate not a limit")
    `DRM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_rate_out) && $stable(o_dose_total), "stalled output word changed")

endmodule

bind dose_rate_alarm_monitor drm_checker u_drm_checker (.*);

`default_nettype wire
